// ===== rtl/core/e8ctu_pkg.sv =====
// e8ctu_pkg: constants and types shared by the e8 call translation undo block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package e8ctu_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned LEN_W       = 31;
    localparam int unsigned OPERAND_W   = 32;

    localparam logic [BYTE_W-1:0] CALL_OPCODE = 8'hE8;
    localparam int unsigned TAIL_GUARD  = 10;
    localparam int unsigned GROUP_BYTES = 5;
    // operand bytes kept before the last one arrives
    localparam int unsigned HELD_DEPTH  = GROUP_BYTES - 2;

    localparam logic [LEN_W-1:0] CHUNK_LENGTH_RST     = 31'd32768;
    localparam logic [LEN_W-1:0] TRANSLATION_SIZE_RST = 31'd12000000;

    // output queue
    localparam int unsigned QUEUE_DEPTH = 8;
    localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W       = PTR_W + 1;

    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHUNK_LENGTH     = 2'd0,
        REG_TRANSLATION_SIZE = 2'd1
    } cfg_reg_t;

    // 0: no group open, else 1 plus number of operand bytes held
    typedef logic [2:0] held_count_t;

endpackage

`default_nettype wire

// ===== rtl/core/e8_call_translation_undo.sv =====
// e8_call_translation_undo: streaming undo of x86 e8 call translation
// uses e8ctu_pkg for constants and types
//
// channel | ports                              | direction | word
// --------+------------------------------------+-----------+---------------------------
// input   | s_valid s_ready s_in_byte          | in        | one chunk byte
// result  | m_valid m_ready m_out_byte         | out       | one translated byte
//         | m_end_of_chunk                     |           | plus final-byte flag
// config  | cfg_valid cfg_ready cfg_index      | in        | register index and value
//         | cfg_data                           |           |
//
// each input word is decoded in the cycle it is accepted and pushes 0 to 5 result
// words into an 8-entry output queue; one result word leaves per cycle while m_ready is high
// throughput is one input word per cycle while s_ready is high; a result word is in the
// queue from the cycle after the input word that completes it
// s_ready drops only when the queue lacks room for the worst case of the next word
// (held count + 1 entries); config writes are always taken
// aresetn is synchronous: clears position, open group and queue, loads reset values
`timescale 1ns / 1ps
`default_nettype none

module e8_call_translation_undo (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // input channel
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [e8ctu_pkg::BYTE_W-1:0]         s_in_byte,
    // result channel
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [e8ctu_pkg::BYTE_W-1:0]              m_out_byte,
    output logic                                      m_end_of_chunk,
    // configuration channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [e8ctu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [e8ctu_pkg::LEN_W-1:0]          cfg_data
);

    localparam int unsigned BW  = e8ctu_pkg::BYTE_W;
    localparam int unsigned LW  = e8ctu_pkg::LEN_W;
    localparam int unsigned OW  = e8ctu_pkg::OPERAND_W;
    localparam int unsigned GB  = e8ctu_pkg::GROUP_BYTES;
    localparam int unsigned HD  = e8ctu_pkg::HELD_DEPTH;
    localparam int unsigned QD  = e8ctu_pkg::QUEUE_DEPTH;
    localparam int unsigned PW  = e8ctu_pkg::PTR_W;
    localparam int unsigned CW  = e8ctu_pkg::CNT_W;

    // configuration
    logic [LW-1:0] chunk_length_reg;
    logic [LW-1:0] translation_size_reg;

    // decode state
    logic [LW-1:0]                byte_position_reg, byte_position_next;
    e8ctu_pkg::held_count_t       held_count_reg, held_count_next;
    logic [BW-1:0]                held_reg [HD];

    // output queue
    logic [BW-1:0] q_byte_reg [QD];
    logic          q_eoc_reg  [QD];
    logic [PW-1:0] head_reg;
    logic [CW-1:0] count_reg, count_next;

    // decode results
    logic          s_acc, m_pop;
    logic          is_final, room_for_group, starts_group;
    logic [BW-1:0] push_byte [GB];
    logic          push_eoc  [GB];
    logic [2:0]    push_n;
    logic          held_we;
    logic [1:0]    held_idx;

    logic [OW-1:0] raw;
    logic [LW-1:0] cur;
    logic [OW:0]   a_ext, neg_cur, fs_ext;
    logic          do_translate;
    logic [OW-1:0] res;
    logic [PW-1:0] wr_ptr;

    assign cfg_ready = 1'b1;

    // keep room for the largest burst the next word can cause
    assign s_ready = (5'(count_reg) + 5'(held_count_reg) + 5'd1) <= 5'(QD);
    assign s_acc   = s_valid && s_ready;

    assign m_valid        = (count_reg != '0);
    assign m_out_byte     = q_byte_reg[head_reg];
    assign m_end_of_chunk = q_eoc_reg[head_reg];
    assign m_pop          = m_valid && m_ready;

    // operand arithmetic
    always_comb begin
        raw     = {s_in_byte, held_reg[2], held_reg[1], held_reg[0]};
        cur     = byte_position_reg - LW'(4);
        a_ext   = {raw[OW-1], raw};
        neg_cur = (OW+1)'(0) - {2'b00, cur};
        fs_ext  = {2'b00, translation_size_reg};
        do_translate = (translation_size_reg != '0)
                    && ($signed(a_ext) >= $signed(neg_cur))
                    && ($signed(a_ext) <  $signed(fs_ext));
        if (!do_translate) begin
            res = raw;
        end else if (raw[OW-1]) begin
            res = raw + {1'b0, translation_size_reg};
        end else begin
            res = raw - {1'b0, cur};
        end
    end

    // per-word decode
    always_comb begin
        is_final       = ({1'b0, byte_position_reg} + 32'd1) >= {1'b0, chunk_length_reg};
        room_for_group = ({1'b0, byte_position_reg} + 32'(e8ctu_pkg::TAIL_GUARD))
                         < {1'b0, chunk_length_reg};
        starts_group   = !is_final && (s_in_byte == e8ctu_pkg::CALL_OPCODE)
                         && room_for_group;

        byte_position_next = is_final ? '0 : byte_position_reg + LW'(1);
        held_count_next    = held_count_reg;
        held_we            = 1'b0;
        held_idx           = 2'(held_count_reg - 3'd1);
        push_n             = '0;
        for (int k = 0; k < GB; k++) begin
            push_byte[k] = s_in_byte;
            push_eoc[k]  = 1'b0;
        end

        priority if (held_count_reg == '0) begin
            if (starts_group) begin
                held_count_next = 3'd1;
            end else begin
                push_eoc[0] = is_final;
                push_n      = 3'd1;
            end
        end else if (is_final) begin
            // chunk ended inside a group: flush untranslated
            push_byte[0] = e8ctu_pkg::CALL_OPCODE;
            for (int k = 1; k <= HD; k++) begin
                if (3'(k) < held_count_reg) begin
                    push_byte[k] = held_reg[k-1];
                end
            end
            for (int k = 1; k < GB; k++) begin
                if (3'(k) == held_count_reg) begin
                    push_eoc[k] = 1'b1;
                end
            end
            push_n          = held_count_reg + 3'd1;
            held_count_next = '0;
        end else if (held_count_reg < 3'd4) begin
            held_we         = 1'b1;
            held_count_next = held_count_reg + 3'd1;
        end else begin
            push_byte[0] = e8ctu_pkg::CALL_OPCODE;
            for (int k = 1; k < GB; k++) begin
                push_byte[k] = res[8*(k-1) +: 8];
            end
            push_n          = 3'(GB);
            held_count_next = '0;
        end
    end

    assign wr_ptr     = head_reg + count_reg[PW-1:0];
    assign count_next = count_reg + (s_acc ? CW'(push_n) : CW'(0)) - CW'(m_pop);

    // control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_length_reg     <= e8ctu_pkg::CHUNK_LENGTH_RST;
            translation_size_reg <= e8ctu_pkg::TRANSLATION_SIZE_RST;
            byte_position_reg    <= '0;
            held_count_reg       <= '0;
            head_reg             <= '0;
            count_reg            <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == e8ctu_pkg::REG_CHUNK_LENGTH) begin
                    chunk_length_reg <= cfg_data;
                end else if (cfg_index == e8ctu_pkg::REG_TRANSLATION_SIZE) begin
                    translation_size_reg <= cfg_data;
                end
            end
            if (s_acc) begin
                byte_position_reg <= byte_position_next;
                held_count_reg    <= held_count_next;
            end
            if (m_pop) begin
                head_reg <= head_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge aclk) begin
        if (s_acc && held_we) begin
            held_reg[held_idx] <= s_in_byte;
        end
        if (s_acc) begin
            for (int k = 0; k < GB; k++) begin
                if (3'(k) < push_n) begin
                    q_byte_reg[wr_ptr + PW'(k)] <= push_byte[k];
                    q_eoc_reg[wr_ptr + PW'(k)]  <= push_eoc[k];
                end
            end
        end
    end

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QD))
        else $error("output queue overflow");

    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_count_reg <= 3'd4)
        else $error("held count out of range");

    a_group_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && held_count_reg == 3'd4) |=>
            (count_reg == $past(count_reg) + CW'(GB) - CW'($past(m_pop))))
        else $error("complete group did not push five words");

    a_pos_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && is_final) |=> (byte_position_reg == '0 && held_count_reg == '0))
        else $error("position or group not cleared at chunk end");

    a_start_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && held_count_reg == '0 && starts_group) |=>
            (held_count_reg == 3'd1 && count_reg == $past(count_reg) - CW'($past(m_pop))))
        else $error("group start produced output");

endmodule

`default_nettype wire
